>>> hdl/periodic_slot_event_scheduler_core_assert.svh
// Assertion macros for the periodic slot event scheduler.
`ifndef PERIODIC_SLOT_EVENT_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_SLOT_EVENT_SCHEDULER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PSES_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/pses_pkg.sv
`default_nettype none

package pses_pkg;

  localparam int unsigned PeriodW      = 16;
  localparam int unsigned PointW       = 6;
  localparam int unsigned ActionW      = 2;
  localparam int unsigned MaskW        = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned IndexW       = 4;
  localparam int unsigned RegAddrW     = 4;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned MaxEventsDef = 16;
  localparam int unsigned MaxPoints    = 32;

  typedef enum logic [ActionW-1:0] {
    ActTick = 2'd0,
    ActAdd  = 2'd1,
    ActSet  = 2'd2,
    ActNop  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegPeriod = 2'd0,
    RegPoints = 2'd1,
    RegDisp   = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

>>> hdl/pses_in_if.sv
`default_nettype none

interface pses_in_if;
  import pses_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [MaskW-1:0]   event_points;
  logic [CountW-1:0]  counter_value;

  modport source (output valid, output action, output event_points, output counter_value,
                  input ready);
  modport sink   (input valid, input action, input event_points, input counter_value,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/pses_out_if.sv
`default_nettype none

interface pses_out_if;
  import pses_pkg::*;

  logic              valid;
  logic              ready;
  logic              fired;
  logic [IndexW-1:0] event_index;
  logic              schedule_done;
  logic              table_full;

  modport source (output valid, output fired, output event_index, output schedule_done,
                  output table_full, input ready);
  modport sink   (input valid, input fired, input event_index, input schedule_done,
                  input table_full, output ready);
endinterface

`default_nettype wire

>>> hdl/periodic_slot_event_scheduler_core.sv
// Periodic slot event scheduler.
// in_i: one beat per action (tick, add event mask, load tick counter).
// out_o: exactly one result beat per input beat, in order.
// APB port (pready tied high): period_length at 0x0, point_count at 0x4,
// disposable_mode at 0x8; user writes only while block is idle, not enforced.
// Add, set and nop actions and a tick with period zero go straight to StFin.
// A tick runs one shared restoring divider, one quotient bit per cycle:
// counter mod period, slot length (period / points), segment / slot length,
// then scans the event table in StLoad and StCheck (one memory read port).
// A tick ends early when the slot is not due or the period, point count or
// slot length is zero.
// in_i.ready is high only when no item is in progress.
// The result sits in an output register; the next item is accepted while it
// waits, but that item cannot finish until out_o.ready takes the old beat.
// Reset clears the counter, event count, fire total, output valid and sets
// period_length=1, point_count=1, disposable_mode=0. Table contents are not
// cleared; only entries below the event count are ever read.
`default_nettype none
`include "periodic_slot_event_scheduler_core_assert.svh"

module periodic_slot_event_scheduler_core #(
  parameter int unsigned MAX_EVENTS = pses_pkg::MaxEventsDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  pses_in_if.sink                           in_i,
  pses_out_if.source                        out_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [pses_pkg::RegAddrW-1:0]     paddr,
  input  wire  [pses_pkg::ApbDataW-1:0]     pwdata,
  output logic [pses_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);
  import pses_pkg::*;

  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMod   = 7'b0000010,
    StSlen  = 7'b0000100,
    StSeg   = 7'b0001000,
    StLoad  = 7'b0010000,
    StCheck = 7'b0100000,
    StFin   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [PeriodW-1:0] period_q;
  logic [PointW-1:0]  points_cfg_q;
  logic               disp_q;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  // architectural state
  logic [CountW-1:0] counter_q, counter_d;
  logic [CW-1:0]     stored_q, stored_d;
  logic [CountW-1:0] fire_total_q, fire_total_d;
  logic [MaskW-1:0]  mem [MAX_EVENTS];
  logic [MaskW-1:0]  rd_q;
  logic              mem_we;

  // latched item
  logic [ActionW-1:0] action_q;
  logic [MaskW-1:0]   emask_q;
  logic [CountW-1:0]  cval_q;

  // shared divider
  logic [PeriodW-1:0]   div_rem_q, div_rem_d;
  logic [CountW-1:0]    div_quo_q, div_quo_d;
  logic [PeriodW-1:0]   div_den_q, div_den_d;
  logic [4:0]           div_cnt_q, div_cnt_d;
  logic [PeriodW:0]     shifted;
  logic [PeriodW+1:0]   diff;
  logic                 ge;
  logic [PeriodW-1:0]   step_rem;
  logic [CountW-1:0]    step_quo;

  logic [PeriodW-1:0] segment_q, segment_d;
  logic [PeriodW-1:0] slot;
  logic [4:0]         slot_bit_q, slot_bit_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               fired_q, fired_d;
  logic               load_rd;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_fired_q, out_done_q, out_full_q;
  logic [IndexW-1:0] out_idx_q;
  logic              out_load;
  logic              out_free;
  logic              full_now;
  logic              done_now;
  logic [CW+IndexW-1:0] idx_ext;

  // APB
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegPeriod: prdata = ApbDataW'(period_q);
      RegPoints: prdata = ApbDataW'(points_cfg_q);
      RegDisp:   prdata = ApbDataW'(disp_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PeriodW'(1);
      points_cfg_q <= PointW'(1);
      disp_q       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegPeriod: period_q     <= pwdata[PeriodW-1:0];
        RegPoints: points_cfg_q <= pwdata[PointW-1:0];
        RegDisp:   disp_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // divider step
  assign shifted  = {div_rem_q, div_quo_q[CountW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, div_den_q};
  assign ge       = ~diff[PeriodW+1];
  assign step_rem = ge ? diff[PeriodW-1:0] : shifted[PeriodW-1:0];
  assign step_quo = {div_quo_q[CountW-2:0], ge};
  assign slot     = step_quo[PeriodW-1:0];

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    div_rem_d    = step_rem;
    div_quo_d    = step_quo;
    div_den_d    = div_den_q;
    div_cnt_d    = div_cnt_q - 5'd1;
    segment_d    = segment_q;
    slot_bit_d   = slot_bit_q;
    idx_d        = idx_q;
    fired_d      = fired_q;
    load_rd      = 1'b0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    full_now     = 1'b0;
    counter_d    = counter_q;
    stored_d     = stored_q;
    fire_total_d = fire_total_q;

    unique case (state_q)
      StIdle: begin
        fired_d = 1'b0;
        idx_d   = '0;
        if (in_i.valid) begin
          if (in_i.action == ActTick && period_q != '0) begin
            div_rem_d = '0;
            div_quo_d = counter_q;
            div_den_d = period_q;
            div_cnt_d = 5'd31;
            state_d   = StMod;
          end else begin
            state_d = StFin;
          end
        end
      end
      StMod: begin
        if (div_cnt_q == 5'd0) begin
          segment_d = step_rem + PeriodW'(1);
          if (points_cfg_q == '0) begin
            state_d = StFin;
          end else begin
            div_rem_d = '0;
            div_quo_d = {period_q, {(CountW-PeriodW){1'b0}}};
            div_den_d = PeriodW'(points_cfg_q);
            div_cnt_d = 5'd15;
            state_d   = StSlen;
          end
        end
      end
      StSlen: begin
        if (div_cnt_q == 5'd0) begin
          if (slot == '0) begin
            state_d = StFin;
          end else begin
            div_rem_d = '0;
            div_quo_d = {segment_q, {(CountW-PeriodW){1'b0}}};
            div_den_d = slot;
            div_cnt_d = 5'd15;
            state_d   = StSeg;
          end
        end
      end
      StSeg: begin
        if (div_cnt_q == 5'd0) begin
          slot_bit_d = 5'(slot - PeriodW'(1));
          if (step_rem != '0 || slot == '0 || slot > PeriodW'(MaskW) ||
              slot > PeriodW'(MaxPoints)) begin
            state_d = StFin;
          end else begin
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        if (idx_q == stored_q) begin
          state_d = StFin;
        end else begin
          load_rd = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (rd_q[slot_bit_q]) begin
          fired_d = 1'b1;
          state_d = StFin;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = StLoad;
        end
      end
      StFin: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
          unique case (action_q)
            ActTick: begin
              counter_d = counter_q + CountW'(1);
              if (fired_q && fire_total_q != '1) begin
                fire_total_d = fire_total_q + CountW'(1);
              end
            end
            ActAdd: begin
              if (stored_q < CW'(MAX_EVENTS)) begin
                mem_we   = 1'b1;
                stored_d = stored_q + CW'(1);
              end else begin
                full_now = 1'b1;
              end
            end
            ActSet: counter_d = cval_q;
            ActNop: ;
            default: ;
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign done_now = disp_q && (fire_total_d >= CountW'(stored_d));
  assign idx_ext  = {{IndexW{1'b0}}, idx_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      counter_q    <= '0;
      stored_q     <= '0;
      fire_total_q <= '0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
      fired_q      <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      counter_q    <= counter_d;
      stored_q     <= stored_d;
      fire_total_q <= fire_total_d;
      out_valid_q  <= out_valid_d;
      div_cnt_q    <= div_cnt_d;
      fired_q      <= fired_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    div_den_q  <= div_den_d;
    segment_q  <= segment_d;
    slot_bit_q <= slot_bit_d;
    if (in_i.valid && in_i.ready) begin
      action_q <= in_i.action;
      emask_q  <= in_i.event_points;
      cval_q   <= in_i.counter_value;
    end
    if (out_load) begin
      out_fired_q <= fired_q;
      out_idx_q   <= fired_q ? idx_ext[IndexW-1:0] : '0;
      out_done_q  <= done_now;
      out_full_q  <= full_now;
    end
  end

  // event table
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[stored_q[AW-1:0]] <= emask_q;
    if (load_rd) rd_q <= mem[idx_q[AW-1:0]];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fired         = out_fired_q;
  assign out_o.event_index   = out_idx_q;
  assign out_o.schedule_done = out_done_q;
  assign out_o.table_full    = out_full_q;

  `PSES_ASSERT(a_stored_bound, clk_i, rst_ni, stored_q <= CW'(MAX_EVENTS), "event count overflow")
  `PSES_ASSERT(a_div_rem, clk_i, rst_ni, !(state_q == StMod || state_q == StSlen || state_q == StSeg) || (div_rem_q < div_den_q), "divider remainder out of range")
  `PSES_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != StIdle, "accepted item not in progress")
  `PSES_ASSERT(a_fire_full, clk_i, rst_ni, !(out_valid_q && out_fired_q && out_full_q), "fire and full in one result")

endmodule

`default_nettype wire
